// ===== hdl/eri_pkg.sv =====
package eri_pkg;

  localparam int COORD_W   = 16;
  localparam int COEF_W    = 16;
  localparam int FRAC_ROT  = 14;
  // widths after the x, y and z axis stages; each holds the largest value the stage can make
  localparam int ROT_W1    = 19;
  localparam int ROT_W2    = 21;
  localparam int ROT_W3    = 23;
  localparam int ROT_LAT   = 6;

  localparam int ISO_W     = 18;
  localparam int ISO_FRAC  = 16;
  localparam int COS30_Q16 = 56756;

  localparam int CFG_IDX_W = 3;

  localparam logic signed [COORD_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [COORD_W-1:0] SAT_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_X = 3'd0,
    CFG_SIN_X = 3'd1,
    CFG_COS_Y = 3'd2,
    CFG_SIN_Y = 3'd3,
    CFG_COS_Z = 3'd4,
    CFG_SIN_Z = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic signed [COORD_W-1:0] qz;
    logic                      clipped;
  } out_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] cos_x;
    logic signed [COEF_W-1:0] sin_x;
    logic signed [COEF_W-1:0] cos_y;
    logic signed [COEF_W-1:0] sin_y;
    logic signed [COEF_W-1:0] cos_z;
    logic signed [COEF_W-1:0] sin_z;
  } cfg_t;

  typedef struct packed {
    logic                      func;
    logic signed [ISO_W-1:0]   x;
    logic signed [ISO_W-1:0]   y;
    logic signed [COORD_W-1:0] z;
  } iso_t;

endpackage

// ===== hdl/euler_rotate_iso_project_unit.sv =====
// Point transform pipeline: func 0 rotates a 16-bit integer point about X, Y, then Z using
// the Q2.14 sine/cosine registers, func 1 applies the isometric projection; results are
// saturated to 16 bits with a clipped flag. One transaction is taken every clock cycle
// (busy is high only in reset and the cycle after it) and its result appears on out_data
// with a one-cycle out_valid strobe after an input register, the three axis stages (each
// registering its products, then its shifted sums) and the saturating output
// register. The receiver cannot stall, so results must be captured on the strobe.
// Coefficient writes take effect at once and should only be made while no transaction is
// in flight.
module euler_rotate_iso_project_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  eri_pkg::in_t                       in_data,
  output logic                               out_valid,
  output eri_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [eri_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic signed [eri_pkg::COEF_W-1:0]  cfg_data
);

  localparam int SW = eri_pkg::COEF_W + 1;

  eri_pkg::cfg_t cfg;
  logic          busy_r;
  logic          s0_valid_r;
  eri_pkg::in_t  s0_r;

  logic signed [SW-1:0] sin_x_e, sin_y_e, sin_z_neg;

  logic                             vx, vy, vz;
  logic signed [eri_pkg::ROT_W1-1:0] y1, z1, x1;
  logic signed [eri_pkg::ROT_W2-1:0] x2, z2, y2;
  logic signed [eri_pkg::ROT_W3-1:0] x3, y3, z3;
  eri_pkg::iso_t                    iso;

  eri_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      s0_valid_r <= 1'b0;
    end else begin
      busy_r     <= 1'b0;
      s0_valid_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= in_data;
  end

  assign busy = busy_r;

  // z stage is the same turn with the sine negated
  assign sin_x_e   = SW'(cfg.sin_x);
  assign sin_y_e   = SW'(cfg.sin_y);
  assign sin_z_neg = -SW'(cfg.sin_z);

  eri_rot_stage #(.IN_W(eri_pkg::COORD_W), .OUT_W(eri_pkg::ROT_W1)) u_rot_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_valid_r),
    .a_i       (s0_r.py),
    .b_i       (s0_r.pz),
    .p_i       (s0_r.px),
    .c_i       (cfg.cos_x),
    .s_i       (sin_x_e),
    .out_valid (vx),
    .a_o       (y1),
    .b_o       (z1),
    .p_o       (x1)
  );

  eri_rot_stage #(.IN_W(eri_pkg::ROT_W1), .OUT_W(eri_pkg::ROT_W2)) u_rot_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vx),
    .a_i       (x1),
    .b_i       (z1),
    .p_i       (y1),
    .c_i       (cfg.cos_y),
    .s_i       (sin_y_e),
    .out_valid (vy),
    .a_o       (x2),
    .b_o       (z2),
    .p_o       (y2)
  );

  eri_rot_stage #(.IN_W(eri_pkg::ROT_W2), .OUT_W(eri_pkg::ROT_W3)) u_rot_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vy),
    .a_i       (x2),
    .b_i       (y2),
    .p_i       (z2),
    .c_i       (cfg.cos_z),
    .s_i       (sin_z_neg),
    .out_valid (vz),
    .a_o       (x3),
    .b_o       (y3),
    .p_o       (z3)
  );

  eri_iso_proj u_iso (
    .clk     (clk),
    .in_data (s0_r),
    .iso_o   (iso)
  );

  eri_sat_out u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .rot_valid (vz),
    .rot_x     (x3),
    .rot_y     (y3),
    .rot_z     (z3),
    .iso_i     (iso),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 8))
    else $error("result strobe without a transaction accepted 8 cycles earlier");

  a_accept_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##8 out_valid)
    else $error("accepted transaction produced no result");

  a_clip_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.clipped) |->
      (out_data.qx == eri_pkg::SAT_MAX || out_data.qx == eri_pkg::SAT_MIN ||
       out_data.qy == eri_pkg::SAT_MAX || out_data.qy == eri_pkg::SAT_MIN ||
       out_data.qz == eri_pkg::SAT_MAX || out_data.qz == eri_pkg::SAT_MIN))
    else $error("clipped flag set with no coordinate at a rail");

endmodule

// ===== hdl/eri_cfg_regs.sv =====
module eri_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [eri_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic signed [eri_pkg::COEF_W-1:0]  cfg_data,
  output eri_pkg::cfg_t                      cfg
);

  eri_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_x <= 16'sd16384;
      cfg_r.sin_x <= 16'sd0;
      cfg_r.cos_y <= 16'sd16384;
      cfg_r.sin_y <= 16'sd0;
      cfg_r.cos_z <= 16'sd16384;
      cfg_r.sin_z <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        eri_pkg::CFG_COS_X: cfg_r.cos_x <= cfg_data;
        eri_pkg::CFG_SIN_X: cfg_r.sin_x <= cfg_data;
        eri_pkg::CFG_COS_Y: cfg_r.cos_y <= cfg_data;
        eri_pkg::CFG_SIN_Y: cfg_r.sin_y <= cfg_data;
        eri_pkg::CFG_COS_Z: cfg_r.cos_z <= cfg_data;
        eri_pkg::CFG_SIN_Z: cfg_r.sin_z <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/eri_rot_stage.sv =====
module eri_rot_stage #(
  parameter int IN_W  = 16,
  parameter int OUT_W = 19
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic signed [IN_W-1:0]              a_i,
  input  logic signed [IN_W-1:0]              b_i,
  input  logic signed [IN_W-1:0]              p_i,
  input  logic signed [eri_pkg::COEF_W-1:0]   c_i,
  input  logic signed [eri_pkg::COEF_W:0]     s_i,
  output logic                                out_valid,
  output logic signed [OUT_W-1:0]             a_o,
  output logic signed [OUT_W-1:0]             b_o,
  output logic signed [OUT_W-1:0]             p_o
);

  localparam int PC_W  = IN_W + eri_pkg::COEF_W;
  localparam int PS_W  = IN_W + eri_pkg::COEF_W + 1;
  localparam int SUM_W = IN_W + eri_pkg::COEF_W + 2;
  localparam int FRAC  = eri_pkg::FRAC_ROT;
  localparam logic signed [SUM_W-1:0] BIAS = SUM_W'((1 << FRAC) - 1);

  logic                   v1_r, v2_r;
  logic signed [PC_W-1:0] ac_r, bc_r;
  logic signed [PS_W-1:0] as_r, bs_r;
  logic signed [IN_W-1:0] p1_r;

  logic signed [SUM_W-1:0] sum_a, sum_b, adj_a, adj_b, sh_a, sh_b;
  logic signed [OUT_W-1:0] a_r, b_r, p2_r;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ac_r <= PC_W'(a_i) * PC_W'(c_i);
    bc_r <= PC_W'(b_i) * PC_W'(c_i);
    as_r <= PS_W'(a_i) * PS_W'(s_i);
    bs_r <= PS_W'(b_i) * PS_W'(s_i);
    p1_r <= p_i;
  end

  // sum and divide by 2^14, truncating toward zero
  always_comb begin
    sum_a = SUM_W'(ac_r) + SUM_W'(bs_r);
    sum_b = SUM_W'(bc_r) - SUM_W'(as_r);
    adj_a = sum_a[SUM_W-1] ? sum_a + BIAS : sum_a;
    adj_b = sum_b[SUM_W-1] ? sum_b + BIAS : sum_b;
    sh_a  = adj_a >>> FRAC;
    sh_b  = adj_b >>> FRAC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= sh_a[OUT_W-1:0];
    b_r  <= sh_b[OUT_W-1:0];
    p2_r <= OUT_W'(p1_r);
  end

  assign out_valid = v2_r;
  assign a_o       = a_r;
  assign b_o       = b_r;
  assign p_o       = p2_r;

endmodule

// ===== hdl/eri_iso_proj.sv =====
module eri_iso_proj (
  input  logic          clk,
  input  eri_pkg::in_t  in_data,
  output eri_pkg::iso_t iso_o
);

  localparam int ISO_DLY = eri_pkg::ROT_LAT - 2;
  localparam int PROD_W  = eri_pkg::COORD_W + 18;
  localparam int YS_W    = eri_pkg::COORD_W + 3;
  localparam logic signed [PROD_W-1:0] COS30 = PROD_W'(eri_pkg::COS30_Q16);
  localparam logic signed [PROD_W-1:0] XBIAS = PROD_W'((1 << eri_pkg::ISO_FRAC) - 1);
  localparam logic signed [YS_W-1:0]   YBIAS = YS_W'(1);

  logic signed [eri_pkg::COORD_W:0] diff;
  logic signed [PROD_W-1:0]         prod_r, xadj, xsh;
  logic signed [YS_W-1:0]           ysum, ys_r, yadj, ysh;
  logic                             func1_r;
  logic signed [eri_pkg::COORD_W-1:0] z1_r;
  eri_pkg::iso_t                    st2_nxt, st2_r;
  eri_pkg::iso_t                    dly_r [ISO_DLY];

  always_comb begin
    diff = (eri_pkg::COORD_W + 1)'(in_data.px) - (eri_pkg::COORD_W + 1)'(in_data.py);
    ysum = YS_W'(in_data.px) + YS_W'(in_data.py) - (YS_W'(in_data.pz) <<< 1);
  end

  always_ff @(posedge clk) begin
    prod_r  <= PROD_W'(diff) * COS30;
    ys_r    <= ysum;
    func1_r <= in_data.func;
    z1_r    <= in_data.pz;
  end

  // truncating divides by 2^16 and by 2
  always_comb begin
    xadj          = prod_r[PROD_W-1] ? prod_r + XBIAS : prod_r;
    xsh           = xadj >>> eri_pkg::ISO_FRAC;
    yadj          = ys_r[YS_W-1] ? ys_r + YBIAS : ys_r;
    ysh           = yadj >>> 1;
    st2_nxt.func  = func1_r;
    st2_nxt.x     = xsh[eri_pkg::ISO_W-1:0];
    st2_nxt.y     = ysh[eri_pkg::ISO_W-1:0];
    st2_nxt.z     = z1_r;
  end

  // delay to line up with the three rotation stages
  always_ff @(posedge clk) begin
    st2_r    <= st2_nxt;
    dly_r[0] <= st2_r;
    for (int i = 1; i < ISO_DLY; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  assign iso_o = dly_r[ISO_DLY-1];

endmodule

// ===== hdl/eri_sat_out.sv =====
module eri_sat_out (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               rot_valid,
  input  logic signed [eri_pkg::ROT_W3-1:0]  rot_x,
  input  logic signed [eri_pkg::ROT_W3-1:0]  rot_y,
  input  logic signed [eri_pkg::ROT_W3-1:0]  rot_z,
  input  eri_pkg::iso_t                      iso_i,
  output logic                               out_valid,
  output eri_pkg::out_t                      out_data
);

  localparam int W = eri_pkg::ROT_W3;
  localparam logic signed [W-1:0] MAXV = W'(eri_pkg::SAT_MAX);
  localparam logic signed [W-1:0] MINV = W'(eri_pkg::SAT_MIN);

  // returns {clip, value}
  function automatic logic [eri_pkg::COORD_W:0] sat16(input logic signed [W-1:0] v);
    logic [eri_pkg::COORD_W:0] r;
    if (v > MAXV) begin
      r = {1'b1, eri_pkg::SAT_MAX};
    end else if (v < MINV) begin
      r = {1'b1, eri_pkg::SAT_MIN};
    end else begin
      r = {1'b0, v[eri_pkg::COORD_W-1:0]};
    end
    return r;
  endfunction

  logic signed [W-1:0]        sel_x, sel_y, sel_z;
  logic [eri_pkg::COORD_W:0]  sx, sy, sz;
  eri_pkg::out_t              out_nxt, out_r;
  logic                       valid_r;

  always_comb begin
    sel_x = iso_i.func ? W'(iso_i.x) : rot_x;
    sel_y = iso_i.func ? W'(iso_i.y) : rot_y;
    sel_z = iso_i.func ? W'(iso_i.z) : rot_z;
    sx = sat16(sel_x);
    sy = sat16(sel_y);
    sz = sat16(sel_z);
    out_nxt.qx      = sx[eri_pkg::COORD_W-1:0];
    out_nxt.qy      = sy[eri_pkg::COORD_W-1:0];
    out_nxt.qz      = sz[eri_pkg::COORD_W-1:0];
    out_nxt.clipped = sx[eri_pkg::COORD_W] | sy[eri_pkg::COORD_W] | sz[eri_pkg::COORD_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= rot_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = out_r;

endmodule
